@@ sv/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the transform matrix unit.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define TRS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define TRS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/trs_pkg.sv @@
// Types and constants of the transform matrix unit.
// No dependencies; used by every module of the block.
`default_nettype none
package trs_pkg;

   typedef struct packed {
      logic               func;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [15:0]        angle_x;
      logic [15:0]        angle_y;
      logic [15:0]        angle_z;
      logic signed [31:0] scl_x;
      logic signed [31:0] scl_y;
      logic signed [31:0] scl_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m03;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
      logic signed [31:0] m13;
      logic signed [31:0] m20;
      logic signed [31:0] m21;
      logic signed [31:0] m22;
      logic signed [31:0] m23;
   } rsp_type;

   // sine/cosine of the three axes, Q16
   typedef struct packed {
      logic signed [17:0] sx;
      logic signed [17:0] cx;
      logic signed [17:0] sy;
      logic signed [17:0] cy;
      logic signed [17:0] sz;
      logic signed [17:0] cz;
   } sc_type;

   localparam int BW = 20;
   // rotation matrix, Q16, [row][col]
   typedef logic [2:0][2:0][BW-1:0] bmat_type;

   localparam logic [30:0] SIN_C9  = 31'd172272;
   localparam logic [30:0] SIN_COEF [4] = '{31'd5026995, 31'd85569306,
                                            31'd693598668, 31'd1686629713};
   localparam logic [31:0] ONE_Q30 = 32'd1073741824;
   localparam logic [14:0] QUARTER = 15'd16384;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam logic FUNC_WORLD = 1'b0;

   function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
      logic signed [31:0] r;
      if (v > 56'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -56'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // quadrant symmetry; {sin, cos}
   function automatic logic [35:0] quad_map(input logic [1:0] quad,
                                            input logic [16:0] sr,
                                            input logic [16:0] cr,
                                            input logic neg);
      logic signed [17:0] s;
      logic signed [17:0] c;
      logic signed [17:0] ps;
      logic signed [17:0] pc;
      ps = signed'({1'b0, sr});
      pc = signed'({1'b0, cr});
      unique case (quad)
         QUAD_0: begin s = ps;  c = pc;  end
         QUAD_1: begin s = pc;  c = -ps; end
         QUAD_2: begin s = -ps; c = -pc; end
         default: begin s = -pc; c = ps; end
      endcase
      if (neg) s = -s;
      return {s, c};
   endfunction

endpackage
`default_nettype wire

@@ sv/trs_transform_matrix_unit_top.sv @@
// Top level of the transform matrix unit: stage control, sine units, rotation and output.
// Depends on trs_pkg, trs_qsine, trs_rot, trs_affine and assert_macros.svh.
//
// Turns one transform beat (position, Euler angles, scale, func) into the top three
// rows of a 4x4 Q16.16 matrix: func 0 gives the world matrix T*Rz*Ry*Rx*S with
// negated angles, func 1 the view matrix Rz*Ry*Rx*T(-pos). Sine and cosine come from
// a six-stage polynomial unit. The pipeline is 13 register stages deep; the first
// stage loads at the accepting edge and the last stage drives rsp. A new beat is
// taken every cycle while req_stall is low. Each stage holds its beat only while the
// stage after it is full and held, so bubbles close up under rsp_stall and req_stall
// rises only when all stages are full and the output is stalled. Outputs saturate to
// the int32 range.
`default_nettype none
`include "assert_macros.svh"
module trs_transform_matrix_unit_top import trs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   localparam int NST = 13;

   logic [NST-1:0] v_ff;
   logic [NST-1:0] en;
   req_type        pl_ff [0:10];
   logic [16:0]    sr [3];
   logic [16:0]    cr [3];
   logic [15:0]    ang0 [3];
   logic [15:0]    ang6 [3];
   sc_type         sc_ff;
   logic [35:0]    mx;
   logic [35:0]    my;
   logic [35:0]    mz;
   bmat_type       bm;

   // a stage may load when it is empty or its own beat moves on
   always_comb begin
      en[NST-1] = !v_ff[NST-1] || !rsp_stall;
      for (int k = NST-2; k >= 0; k--)
         en[k] = !v_ff[k] || en[k+1];
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_valid;
         for (int k = 1; k < NST; k++)
            if (en[k]) v_ff[k] <= v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) pl_ff[0] <= req_data;
      for (int k = 1; k <= 10; k++)
         if (en[k]) pl_ff[k] <= pl_ff[k-1];
   end

   assign ang0 = '{pl_ff[0].angle_x, pl_ff[0].angle_y, pl_ff[0].angle_z};
   assign ang6 = '{pl_ff[6].angle_x, pl_ff[6].angle_y, pl_ff[6].angle_z};

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic [14:0] r;
      assign r = {1'b0, ang0[a][13:0]};
      trs_qsine u_sin (
         .clock (clock),
         .en    (en[6:1]),
         .r     (r),
         .q     (sr[a])
      );
      trs_qsine u_cos (
         .clock (clock),
         .en    (en[6:1]),
         .r     (QUARTER - r),
         .q     (cr[a])
      );
   end

   assign mx = quad_map(ang6[0][15:14], sr[0], cr[0], pl_ff[6].func == FUNC_WORLD);
   assign my = quad_map(ang6[1][15:14], sr[1], cr[1], pl_ff[6].func == FUNC_WORLD);
   assign mz = quad_map(ang6[2][15:14], sr[2], cr[2], pl_ff[6].func == FUNC_WORLD);

   always_ff @(posedge clock) begin
      if (en[7]) sc_ff <= {mx, my, mz};
   end

   trs_rot u_rot (
      .clock (clock),
      .en    (en[10:8]),
      .sc    (sc_ff),
      .b     (bm)
   );

   trs_affine u_aff (
      .clock (clock),
      .en    (en[12:11]),
      .b     (bm),
      .d     (pl_ff[10]),
      .m     (rsp_data)
   );

   assign rsp_valid = v_ff[NST-1];

   `TRS_ASSERT_IMP(a_stall_only_full, clock, reset, req_stall, (&v_ff) && rsp_stall, "input held back with room in pipeline")
   `TRS_ASSERT_IMP(a_cos_range, clock, reset, v_ff[7], (sc_ff.cx <= 18'sd65536) && (sc_ff.cx >= -18'sd65536), "cosine out of range")
   `TRS_ASSERT_NXT(a_no_drop, clock, reset, v_ff[NST-2] && rsp_valid && rsp_stall, v_ff[NST-2] && rsp_valid, "beat lost under stall")

endmodule
`default_nettype wire

@@ sv/trs_qsine.sv @@
// Six-stage quarter-wave sine: odd polynomial in Q2.30, rounded to Q16.
// Depends on trs_pkg.
`default_nettype none
module trs_qsine import trs_pkg::*; (
   input  wire logic        clock,
   input  wire logic [5:0]  en,
   input  wire logic [14:0] r,
   output logic [16:0]      q
);
   logic [30:0] x_ff  [1:5];
   logic [30:0] xx_ff [1:5];
   logic [30:0] t_ff  [1:5];
   logic [30:0] x_in;
   logic [61:0] sq;
   logic [61:0] fin_prod;
   logic [31:0] s;
   logic [31:0] s_cl;
   logic [16:0] q_ff;

   assign x_in = {r, 16'd0};
   assign sq   = 62'(x_in) * 62'(x_in);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff[1]  <= x_in;
         xx_ff[1] <= sq[60:30];
         t_ff[1]  <= SIN_C9;
      end
   end

   for (genvar k = 2; k <= 5; k++) begin : g_horner
      logic [61:0] p;
      assign p = 62'(xx_ff[k-1]) * 62'(t_ff[k-1]);
      always_ff @(posedge clock) begin
         if (en[k-1]) begin
            x_ff[k]  <= x_ff[k-1];
            xx_ff[k] <= xx_ff[k-1];
            t_ff[k]  <= SIN_COEF[k-2] - p[60:30];
         end
      end
   end

   assign fin_prod = 62'(x_ff[5]) * 62'(t_ff[5]);
   assign s        = fin_prod[61:30];
   assign s_cl     = (s > ONE_Q30) ? ONE_Q30 : s;

   always_ff @(posedge clock) begin
      if (en[5]) q_ff <= 17'((s_cl + 32'd8192) >> 14);
   end

   assign q = q_ff;
endmodule
`default_nettype wire

@@ sv/trs_rot.sv @@
// Three-stage product Rz*Ry*Rx from the axis sines and cosines, rounded to Q16.
// Depends on trs_pkg.
`default_nettype none
module trs_rot import trs_pkg::*; (
   input  wire logic     clock,
   input  wire logic [2:0] en,
   input  wire sc_type   sc,
   output bmat_type      b
);
   logic signed [35:0] a_in [3][3];
   logic signed [35:0] a_ff [3][3];
   logic signed [17:0] cx_ff;
   logic signed [17:0] sx_ff;
   logic signed [35:0] a0_ff [3];
   logic signed [53:0] p_ff  [3][4];
   bmat_type b_ff;

   always_comb begin
      a_in[0][0] = 36'(sc.cz) * 36'(sc.cy);
      a_in[0][1] = -(36'(sc.sz) <<< 16);
      a_in[0][2] = 36'(sc.cz) * 36'(sc.sy);
      a_in[1][0] = 36'(sc.sz) * 36'(sc.cy);
      a_in[1][1] = 36'(sc.cz) <<< 16;
      a_in[1][2] = 36'(sc.sz) * 36'(sc.sy);
      a_in[2][0] = -(36'(sc.sy) <<< 16);
      a_in[2][1] = '0;
      a_in[2][2] = 36'(sc.cy) <<< 16;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_ff  <= a_in;
         cx_ff <= sc.cx;
         sx_ff <= sc.sx;
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_row
      logic signed [54:0] s1;
      logic signed [54:0] s2;
      logic signed [36:0] s0;
      always_ff @(posedge clock) begin
         if (en[1]) begin
            a0_ff[i]   <= a_ff[i][0];
            p_ff[i][0] <= 54'(a_ff[i][1]) * 54'(cx_ff);
            p_ff[i][1] <= 54'(a_ff[i][2]) * 54'(sx_ff);
            p_ff[i][2] <= 54'(a_ff[i][1]) * 54'(sx_ff);
            p_ff[i][3] <= 54'(a_ff[i][2]) * 54'(cx_ff);
         end
      end
      assign s0 = 37'(a0_ff[i]) + 37'sd32768;
      assign s1 = 55'(p_ff[i][0]) + 55'(p_ff[i][1]) + (55'sd1 <<< 31);
      assign s2 = 55'(p_ff[i][3]) - 55'(p_ff[i][2]) + (55'sd1 <<< 31);
      always_ff @(posedge clock) begin
         if (en[2]) begin
            b_ff[i][0] <= BW'(s0 >>> 16);
            b_ff[i][1] <= BW'(s1 >>> 32);
            b_ff[i][2] <= BW'(s2 >>> 32);
         end
      end
   end

   assign b = b_ff;
endmodule
`default_nettype wire

@@ sv/trs_affine.sv @@
// Two-stage scale (world) or negated-translation (view) step with saturation.
// Depends on trs_pkg.
`default_nettype none
module trs_affine import trs_pkg::*; (
   input  wire logic     clock,
   input  wire logic [1:0] en,
   input  wire bmat_type b,
   input  wire req_type  d,
   output rsp_type       m
);
   logic signed [32:0] op [3];
   logic signed [31:0] pos [3];
   logic signed [52:0] prod_ff [3][3];
   logic signed [31:0] pos_ff [3];
   logic               func_ff;
   bmat_type           b_ff;
   logic signed [31:0] mm [3][4];
   rsp_type            m_ff;

   assign pos = '{d.pos_x, d.pos_y, d.pos_z};

   always_comb begin
      op[0] = d.func ? -33'(d.pos_x) : 33'(d.scl_x);
      op[1] = d.func ? -33'(d.pos_y) : 33'(d.scl_y);
      op[2] = d.func ? -33'(d.pos_z) : 33'(d.scl_z);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= 53'($signed(b[i][j])) * 53'(op[j]);
            end
            pos_ff[i] <= pos[i];
         end
         func_ff <= d.func;
         b_ff    <= b;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [55:0] acc;
         acc = 56'(prod_ff[i][0]) + 56'(prod_ff[i][1]) + 56'(prod_ff[i][2])
               + 56'sd32768;
         if (func_ff == FUNC_WORLD) begin
            for (int j = 0; j < 3; j++)
               mm[i][j] = sat32((56'(prod_ff[i][j]) + 56'sd32768) >>> 16);
            mm[i][3] = pos_ff[i];
         end else begin
            for (int j = 0; j < 3; j++)
               mm[i][j] = 32'($signed(b_ff[i][j]));
            mm[i][3] = sat32(acc >>> 16);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         m_ff <= '{mm[0][0], mm[0][1], mm[0][2], mm[0][3],
                   mm[1][0], mm[1][1], mm[1][2], mm[1][3],
                   mm[2][0], mm[2][1], mm[2][2], mm[2][3]};
      end
   end

   assign m = m_ff;
endmodule
`default_nettype wire
